// File: src/midi_track_event_parser_assert.svh
// ----------------------------------------------------------------------------
// midi_track_event_parser_assert.svh
// Assertion macros shared by the track event parser modules.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off during reset
`define MTEP_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MTEP_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define MTEP_ASSERT_IMP(label, pre, post, msg)
`define MTEP_ASSERT_NXT(label, pre, post, msg)

`endif

`endif

// File: src/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// Types, codes and helpers shared by the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

    // Parser phases
    typedef enum logic [3:0] {
        PH_DELTA  = 4'd0,
        PH_STATUS = 4'd1,
        PH_DATA1  = 4'd2,
        PH_DATA2  = 4'd3,
        PH_MTYPE  = 4'd4,
        PH_MLEN   = 4'd5,
        PH_MPAY   = 4'd6,
        PH_SLEN   = 4'd7,
        PH_SPAY   = 4'd8
    } phase_t;

    // Event classes
    localparam logic [3:0] CLS_NOTE_OFF   = 4'd0;
    localparam logic [3:0] CLS_NOTE_ON    = 4'd1;
    localparam logic [3:0] CLS_CONTROL    = 4'd2;
    localparam logic [3:0] CLS_PROGRAM    = 4'd3;
    localparam logic [3:0] CLS_OTHER      = 4'd4;
    localparam logic [3:0] CLS_SYSEX      = 4'd5;
    localparam logic [3:0] CLS_META_TEXT  = 4'd6;
    localparam logic [3:0] CLS_TEMPO      = 4'd7;
    localparam logic [3:0] CLS_TIME_SIG   = 4'd8;
    localparam logic [3:0] CLS_META_OTHER = 4'd9;

    // Fault codes
    localparam logic [1:0] FLT_NONE     = 2'd0;
    localparam logic [1:0] FLT_TRUNC    = 2'd1;
    localparam logic [1:0] FLT_OVERFLOW = 2'd2;
    localparam logic [1:0] FLT_STATUS   = 2'd3;

    // Byte codes
    localparam logic [7:0] ST_META       = 8'hFF;
    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
    localparam logic [7:0] MT_TEMPO      = 8'h51;
    localparam logic [7:0] MT_TIME_SIG   = 8'h58;
    localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
    localparam logic [3:0] NIB_CONTROL   = 4'hB;
    localparam logic [3:0] NIB_PROGRAM   = 4'hC;
    localparam logic [3:0] NIB_PRESSURE  = 4'hD;
    localparam logic [3:0] NIB_SYSTEM    = 4'hF;

    localparam logic [27:0] VLQ_SAT = 28'hFFFFFFF;

    // One classified byte, as passed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       ts;        // first byte of a track
        logic       lb;        // last byte of the track
        logic       hi;        // bit 7 set
        logic       meta;      // FF
        logic       sysex;     // F0 or F7
        logic       bad;       // F1..FE other than F7
        logic       valued;    // tempo or time signature meta type
    } item_t;

    // Class of an event from its status and meta type
    function automatic logic [3:0] class_of(input logic [7:0] s, input logic [7:0] mt);
        logic [3:0] c;
        begin
            c = CLS_OTHER;
            if (s == ST_META) begin
                if (mt == MT_TEMPO) c = CLS_TEMPO;
                else if (mt == MT_TIME_SIG) c = CLS_TIME_SIG;
                else if (mt != 8'h00 && mt[7:4] == 4'h0) c = CLS_META_TEXT;
                else c = CLS_META_OTHER;
            end else if (s == ST_SYSEX || s == ST_SYSEX_ESC) begin
                c = CLS_SYSEX;
            end else begin
                case (s[7:4])
                    NIB_NOTE_OFF: c = CLS_NOTE_OFF;
                    NIB_NOTE_ON:  c = CLS_NOTE_ON;
                    NIB_CONTROL:  c = CLS_CONTROL;
                    NIB_PROGRAM:  c = CLS_PROGRAM;
                    default:      c = CLS_OTHER;
                endcase
            end
            return c;
        end
    endfunction

endpackage

// File: src/mtep_front.sv
// ----------------------------------------------------------------------------
// mtep_front
// Takes input bytes, tags each with its byte class and pushes it to the queue.
// ----------------------------------------------------------------------------
module mtep_front (
    input  logic          [7:0] data_byte,
    input  logic                track_start,
    input  logic                last_byte,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                q_full,
    output logic                push,
    output mtep_pkg::item_t     push_item
);
    import mtep_pkg::*;

    // Stall only while the queue has no room
    assign item_stall = q_full;
    assign push       = item_valid;

    // Byte classification
    always_comb
    begin
        push_item.data   = data_byte;
        push_item.ts     = track_start;
        push_item.lb     = last_byte;
        push_item.hi     = data_byte[7];
        push_item.meta   = (data_byte == ST_META);
        push_item.sysex  = (data_byte == ST_SYSEX) || (data_byte == ST_SYSEX_ESC);
        push_item.bad    = (data_byte[7:4] == NIB_SYSTEM) && (data_byte != ST_SYSEX)
                           && (data_byte != ST_META) && (data_byte != ST_SYSEX_ESC);
        push_item.valued = (data_byte == MT_TEMPO) || (data_byte == MT_TIME_SIG);
    end

endmodule

// File: src/mtep_queue.sv
// ----------------------------------------------------------------------------
// mtep_queue
// Two-entry queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
`include "midi_track_event_parser_assert.svh"

module mtep_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mtep_pkg::item_t  push_item,
    output logic             q_full,
    output logic             q_valid,
    output mtep_pkg::item_t  q_item,
    input  logic             pop
);
    import mtep_pkg::*;

    item_t       entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign q_full  = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    // Storage, write side
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign q_item = entry_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Checks
    `MTEP_ASSERT_IMP(a_q_count_range, 1'b1, count_reg != 2'd3, "queue count out of range")
    `MTEP_ASSERT_IMP(a_q_ptr_gap, count_reg == 2'd0 || count_reg == 2'd2, wr_ptr_reg == rd_ptr_reg, "queue pointers disagree with count")

endmodule

// File: src/mtep_back.sv
// ----------------------------------------------------------------------------
// mtep_back
// Parser state machine: one queued byte per cycle while no result is held
// stalled; result into an output register that holds while the receiver stalls.
// ----------------------------------------------------------------------------
`include "midi_track_event_parser_assert.svh"

module mtep_back #(
    parameter int MAX_VLQ_BYTES = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  mtep_pkg::item_t  q_item,
    output logic             pop,
    output logic             event_valid,
    input  logic             event_stall,
    output logic      [3:0]  event_class,
    output logic      [3:0]  channel,
    output logic     [27:0]  event_delta,
    output logic      [7:0]  status_byte,
    output logic      [7:0]  data_first,
    output logic      [7:0]  data_second,
    output logic     [31:0]  payload_value,
    output logic      [7:0]  meta_type,
    output logic             running_used,
    output logic      [1:0]  fault
);
    import mtep_pkg::*;

    localparam logic [3:0] VLQ_LIMIT = 4'(MAX_VLQ_BYTES);

    // Parser state
    phase_t       phase_reg, phase_next;
    logic [27:0]  vlq_acc_reg, vlq_acc_next;
    logic  [3:0]  vlq_cnt_reg, vlq_cnt_next;
    logic         vlq_over_reg, vlq_over_next;
    logic [27:0]  delta_reg, delta_next;
    logic         ev_over_reg, ev_over_next;
    logic  [7:0]  last_st_reg, last_st_next;
    logic  [7:0]  cur_st_reg, cur_st_next;
    logic  [7:0]  first_reg, first_next;
    logic  [7:0]  mtype_reg, mtype_next;
    logic         valued_reg, valued_next;
    logic [27:0]  rem_reg, rem_next;
    logic [31:0]  val_reg, val_next;
    logic         run_reg, run_next;

    // Output register
    logic         out_v_reg, out_v_next;
    logic  [3:0]  o_class_reg, o_class_next;
    logic  [3:0]  o_chan_reg, o_chan_next;
    logic [27:0]  o_delta_reg, o_delta_next;
    logic  [7:0]  o_status_reg, o_status_next;
    logic  [7:0]  o_first_reg, o_first_next;
    logic  [7:0]  o_second_reg, o_second_next;
    logic [31:0]  o_value_reg, o_value_next;
    logic  [7:0]  o_mtype_reg, o_mtype_next;
    logic         o_run_reg, o_run_next;
    logic  [1:0]  o_fault_reg, o_fault_next;

    logic         fire;
    logic         emit;

    // A byte is taken when the output register is free or draining
    assign fire = q_valid && (!out_v_reg || !event_stall);
    assign pop  = fire;

    // Byte step
    always_comb
    begin
        logic        ovf_now;
        logic        over1;
        logic        fin;
        logic        feed;
        logic [27:0] acc1;
        logic [27:0] vval;
        logic  [3:0] cnt1;
        logic        done;
        logic        take_first;
        logic  [1:0] flt;
        logic  [7:0] second;
        logic        clean;
        logic        voice;
        logic  [7:0] b;

        phase_next    = phase_reg;
        vlq_acc_next  = vlq_acc_reg;
        vlq_cnt_next  = vlq_cnt_reg;
        vlq_over_next = vlq_over_reg;
        delta_next    = delta_reg;
        ev_over_next  = ev_over_reg;
        last_st_next  = last_st_reg;
        cur_st_next   = cur_st_reg;
        first_next    = first_reg;
        mtype_next    = mtype_reg;
        valued_next   = valued_reg;
        rem_next      = rem_reg;
        val_next      = val_reg;
        run_next      = run_reg;

        b          = q_item.data;
        emit       = 1'b0;
        done       = 1'b0;
        take_first = 1'b0;
        feed       = 1'b0;
        flt        = FLT_NONE;
        second     = 8'h00;
        clean      = 1'b0;
        ovf_now    = 1'b0;
        over1      = 1'b0;
        fin        = 1'b0;
        acc1       = 28'h0;
        vval       = 28'h0;
        cnt1       = 4'h0;
        voice      = 1'b0;

        o_class_next  = o_class_reg;
        o_chan_next   = o_chan_reg;
        o_delta_next  = o_delta_reg;
        o_status_next = o_status_reg;
        o_first_next  = o_first_reg;
        o_second_next = o_second_reg;
        o_value_next  = o_value_reg;
        o_mtype_next  = o_mtype_reg;
        o_run_next    = o_run_reg;
        o_fault_next  = o_fault_reg;

        if (fire)
        begin
            // New track clears everything before the byte
            if (q_item.ts)
            begin
                phase_next    = PH_DELTA;
                vlq_acc_next  = 28'h0;
                vlq_cnt_next  = 4'h0;
                vlq_over_next = 1'b0;
                delta_next    = 28'h0;
                ev_over_next  = 1'b0;
                last_st_next  = 8'h00;
                cur_st_next   = 8'h00;
                first_next    = 8'h00;
                mtype_next    = 8'h00;
                valued_next   = 1'b0;
                rem_next      = 28'h0;
                val_next      = 32'h0;
                run_next      = 1'b0;
            end

            // Variable-length decode of this byte
            ovf_now = (vlq_cnt_next >= VLQ_LIMIT) || (vlq_acc_next[27:21] != 7'h0);
            over1   = vlq_over_next || ovf_now;
            acc1    = ovf_now ? vlq_acc_next : {vlq_acc_next[20:0], b[6:0]};
            cnt1    = (vlq_cnt_next != 4'hF) ? vlq_cnt_next + 4'h1 : vlq_cnt_next;
            fin     = !q_item.hi;
            vval    = over1 ? VLQ_SAT : acc1;

            case (phase_next)
                PH_DELTA:
                begin
                    feed = 1'b1;
                    if (fin)
                    begin
                        delta_next = vval;
                        phase_next = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    if (q_item.hi)
                    begin
                        run_next    = 1'b0;
                        cur_st_next = b;
                        if (q_item.meta)
                        begin
                            last_st_next = 8'h00;
                            phase_next   = PH_MTYPE;
                        end
                        else if (q_item.sysex)
                        begin
                            last_st_next = 8'h00;
                            phase_next   = PH_SLEN;
                        end
                        else if (q_item.bad)
                        begin
                            last_st_next = 8'h00;
                            emit = 1'b1;
                            flt  = FLT_STATUS;
                            done = 1'b1;
                        end
                        else
                        begin
                            last_st_next = b;
                            phase_next   = PH_DATA1;
                        end
                    end
                    else if (last_st_next == 8'h00)
                    begin
                        cur_st_next = 8'h00;
                        first_next  = b;
                        emit = 1'b1;
                        flt  = FLT_STATUS;
                        done = 1'b1;
                    end
                    else
                    begin
                        cur_st_next = last_st_next;
                        run_next    = 1'b1;
                        take_first  = 1'b1;
                    end
                end
                PH_DATA1:
                begin
                    take_first = 1'b1;
                end
                PH_DATA2:
                begin
                    second = b;
                    emit   = 1'b1;
                    done   = 1'b1;
                end
                PH_MTYPE:
                begin
                    mtype_next  = b;
                    valued_next = q_item.valued;
                    phase_next  = PH_MLEN;
                end
                PH_MLEN:
                begin
                    feed = 1'b1;
                    if (fin)
                    begin
                        rem_next = vval;
                        val_next = valued_next ? 32'h0 : {4'h0, vval};
                        if (!valued_next || vval == 28'h0)
                        begin
                            emit = 1'b1;
                        end
                        if (vval == 28'h0)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_MPAY;
                        end
                    end
                end
                PH_MPAY:
                begin
                    if (valued_next)
                    begin
                        val_next = {val_next[23:0], b};
                    end
                    rem_next = rem_next - 28'h1;
                    if (rem_next == 28'h0)
                    begin
                        done = 1'b1;
                        emit = valued_next;
                    end
                end
                PH_SLEN:
                begin
                    feed = 1'b1;
                    if (fin)
                    begin
                        rem_next = vval;
                        val_next = {4'h0, vval};
                        emit     = 1'b1;
                        if (vval == 28'h0)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_SPAY;
                        end
                    end
                end
                PH_SPAY:
                begin
                    rem_next = rem_next - 28'h1;
                    if (rem_next == 28'h0)
                    begin
                        done = 1'b1;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase

            // Decoder state update
            if (feed)
            begin
                if (fin)
                begin
                    ev_over_next  = ev_over_next || over1;
                    vlq_acc_next  = 28'h0;
                    vlq_cnt_next  = 4'h0;
                    vlq_over_next = 1'b0;
                end
                else
                begin
                    vlq_acc_next  = acc1;
                    vlq_cnt_next  = cnt1;
                    vlq_over_next = over1;
                end
            end

            // First data byte of a voice event
            if (take_first)
            begin
                first_next = b;
                if (cur_st_next[7:4] == NIB_PROGRAM || cur_st_next[7:4] == NIB_PRESSURE)
                begin
                    emit = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    phase_next = PH_DATA2;
                end
            end

            // Track end in the middle of an event
            if (q_item.lb && !done)
            begin
                clean = (phase_next == PH_DELTA) && (vlq_cnt_next == 4'h0) && !vlq_over_next;
                if (!clean)
                begin
                    emit = 1'b1;
                    if (flt != FLT_STATUS)
                    begin
                        flt = FLT_TRUNC;
                    end
                end
            end
            if (emit && flt == FLT_NONE && ev_over_next)
            begin
                flt = FLT_OVERFLOW;
            end

            // Result fields
            voice = cur_st_next[7] && (cur_st_next[7:4] != NIB_SYSTEM);
            if (emit)
            begin
                o_class_next  = class_of(cur_st_next, mtype_next);
                o_chan_next   = voice ? cur_st_next[3:0] : 4'h0;
                o_delta_next  = delta_next;
                o_status_next = cur_st_next;
                o_first_next  = (voice || flt == FLT_STATUS) ? first_next : 8'h00;
                o_second_next = voice ? second : 8'h00;
                o_value_next  = voice ? 32'h0 : val_next;
                o_mtype_next  = (cur_st_next == ST_META) ? mtype_next : 8'h00;
                o_run_next    = run_next;
                o_fault_next  = flt;
            end

            // End of event or of track
            if (q_item.lb || done)
            begin
                phase_next    = PH_DELTA;
                vlq_acc_next  = 28'h0;
                vlq_cnt_next  = 4'h0;
                vlq_over_next = 1'b0;
                delta_next    = 28'h0;
                ev_over_next  = 1'b0;
                cur_st_next   = 8'h00;
                first_next    = 8'h00;
                mtype_next    = 8'h00;
                valued_next   = 1'b0;
                rem_next      = 28'h0;
                val_next      = 32'h0;
                run_next      = 1'b0;
                if (q_item.lb)
                begin
                    last_st_next = 8'h00;
                end
            end
        end
    end

    // Output valid: set on a new result, cleared when taken
    always_comb
    begin
        if (fire && emit)
        begin
            out_v_next = 1'b1;
        end
        else if (!event_stall)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_DELTA;
            vlq_acc_reg  <= 28'h0;
            vlq_cnt_reg  <= 4'h0;
            vlq_over_reg <= 1'b0;
            delta_reg    <= 28'h0;
            ev_over_reg  <= 1'b0;
            last_st_reg  <= 8'h00;
            cur_st_reg   <= 8'h00;
            first_reg    <= 8'h00;
            mtype_reg    <= 8'h00;
            valued_reg   <= 1'b0;
            rem_reg      <= 28'h0;
            val_reg      <= 32'h0;
            run_reg      <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            vlq_acc_reg  <= vlq_acc_next;
            vlq_cnt_reg  <= vlq_cnt_next;
            vlq_over_reg <= vlq_over_next;
            delta_reg    <= delta_next;
            ev_over_reg  <= ev_over_next;
            last_st_reg  <= last_st_next;
            cur_st_reg   <= cur_st_next;
            first_reg    <= first_next;
            mtype_reg    <= mtype_next;
            valued_reg   <= valued_next;
            rem_reg      <= rem_next;
            val_reg      <= val_next;
            run_reg      <= run_next;
            out_v_reg    <= out_v_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        o_class_reg  <= o_class_next;
        o_chan_reg   <= o_chan_next;
        o_delta_reg  <= o_delta_next;
        o_status_reg <= o_status_next;
        o_first_reg  <= o_first_next;
        o_second_reg <= o_second_next;
        o_value_reg  <= o_value_next;
        o_mtype_reg  <= o_mtype_next;
        o_run_reg    <= o_run_next;
        o_fault_reg  <= o_fault_next;
    end

    assign event_valid   = out_v_reg;
    assign event_class   = o_class_reg;
    assign channel       = o_chan_reg;
    assign event_delta   = o_delta_reg;
    assign status_byte   = o_status_reg;
    assign data_first    = o_first_reg;
    assign data_second   = o_second_reg;
    assign payload_value = o_value_reg;
    assign meta_type     = o_mtype_reg;
    assign running_used  = o_run_reg;
    assign fault         = o_fault_reg;

    // Checks
    `MTEP_ASSERT_NXT(a_emit_shows, fire && emit, out_v_reg, "result not presented")
    `MTEP_ASSERT_NXT(a_track_end_clears, fire && q_item.lb, phase_reg == PH_DELTA && last_st_reg == 8'h00, "track end left parser state")
    `MTEP_ASSERT_IMP(a_running_voice, run_reg, cur_st_reg[7] && cur_st_reg[7:4] != NIB_SYSTEM, "running status is not a voice status")

endmodule

// File: src/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Decodes standard MIDI file track events from a stream of chunk data bytes.
// Input channel: data_byte, track_start, last_byte with item_valid/item_stall.
// Output channel: one decoded event per item on event_valid/event_stall.
// Taken bytes pass a classifier, a two-entry queue and the parser, which
// steps once per byte; a byte can be taken every cycle (one byte per cycle
// sustained) while no result waits on a stalled receiver. The last defining
// byte of an event goes into a queue entry, then the result into the output register.
// While a result waits on a stalled receiver, the result register holds
// and the parser halts; the queue fills and item_stall rises after at most two
// more bytes.
// Reset clears the parser, running status, queue and output valid. A byte
// with track_start set clears the parser before it is decoded; after a byte
// with last_byte set the parser and running status are cleared.
// ----------------------------------------------------------------------------
module midi_track_event_parser #(
    parameter int MAX_VLQ_BYTES = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic  [7:0]  data_byte,
    input  logic         track_start,
    input  logic         last_byte,
    input  logic         item_valid,
    output logic         item_stall,
    output logic         event_valid,
    input  logic         event_stall,
    output logic  [3:0]  event_class,
    output logic  [3:0]  channel,
    output logic [27:0]  event_delta,
    output logic  [7:0]  status_byte,
    output logic  [7:0]  data_first,
    output logic  [7:0]  data_second,
    output logic [31:0]  payload_value,
    output logic  [7:0]  meta_type,
    output logic         running_used,
    output logic  [1:0]  fault
);
    import mtep_pkg::*;

    logic   push;
    item_t  push_item;
    logic   q_full;
    logic   q_valid;
    item_t  q_item;
    logic   pop;

    // Front: classify and enqueue
    mtep_front u_front (
        .data_byte  (data_byte),
        .track_start(track_start),
        .last_byte  (last_byte),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .q_full     (q_full),
        .push       (push),
        .push_item  (push_item)
    );

    // Queue between front and back
    mtep_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_item(push_item),
        .q_full   (q_full),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop)
    );

    // Back: parse and present results
    mtep_back #(
        .MAX_VLQ_BYTES(MAX_VLQ_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .pop          (pop),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_class  (event_class),
        .channel      (channel),
        .event_delta  (event_delta),
        .status_byte  (status_byte),
        .data_first   (data_first),
        .data_second  (data_second),
        .payload_value(payload_value),
        .meta_type    (meta_type),
        .running_used (running_used),
        .fault        (fault)
    );

endmodule

// File: tb/midi_track_event_parser_test.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser_test
// Streams track chunk bytes into the parser and checks every decoded event
// against an in-bench model of the parser state machine. A few hand-built
// events come first. Random tracks follow, mostly well-formed with random
// content, mixed with truncations, missing track ends, bad statuses and
// overlong lengths. In the second random run both sides idle and stall at random.
// ----------------------------------------------------------------------------
module midi_track_event_parser_test;

    import mtep_pkg::*;

    localparam int          VLQ_LIMIT    = 4;
    localparam logic [27:0] VLQ_MAX      = 28'hFFFFFFF;
    localparam int          DRAIN_CYCLES = 40;

    // One decoded event, fields in port order
    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  chan;
        logic [27:0] delta;
        logic [7:0]  status;
        logic [7:0]  first;
        logic [7:0]  second;
        logic [31:0] value;
        logic [7:0]  mtype;
        logic        reused;
        logic [1:0]  flt;
    } midi_event_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic [7:0]  data_byte;
    logic        track_start;
    logic        last_byte;
    logic        item_valid;
    logic        item_stall;
    logic        event_valid;
    logic        event_stall = 1'b0;
    logic [3:0]  event_class;
    logic [3:0]  channel;
    logic [27:0] event_delta;
    logic [7:0]  status_byte;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [31:0] payload_value;
    logic [7:0]  meta_type;
    logic        running_used;
    logic [1:0]  fault;

    // Parser model state
    phase_t      step_phase;
    logic [27:0] vlq_acc;
    logic [3:0]  vlq_cnt;
    logic        vlq_ovf;
    logic [27:0] hold_delta;
    logic        evt_ovf;
    logic [7:0]  run_status;
    logic [7:0]  cur_status;
    logic [7:0]  hold_first;
    logic [7:0]  hold_mtype;
    logic [27:0] remain;
    logic [31:0] value_acc;
    logic        reused;

    midi_event_t events_due[$];
    logic [7:0]  track_buf[$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    bit          idle_on = 1'b0;
    int          stall_run = 0;

    midi_track_event_parser #(
        .MAX_VLQ_BYTES(VLQ_LIMIT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .track_start  (track_start),
        .last_byte    (last_byte),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_class  (event_class),
        .channel      (channel),
        .event_delta  (event_delta),
        .status_byte  (status_byte),
        .data_first   (data_first),
        .data_second  (data_second),
        .payload_value(payload_value),
        .meta_type    (meta_type),
        .running_used (running_used),
        .fault        (fault)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    function automatic void clear_event();
        step_phase = PH_DELTA;
        vlq_acc    = '0;
        vlq_cnt    = '0;
        vlq_ovf    = 1'b0;
        hold_delta = '0;
        evt_ovf    = 1'b0;
        cur_status = '0;
        hold_first = '0;
        hold_mtype = '0;
        remain     = '0;
        value_acc  = '0;
        reused     = 1'b0;
    endfunction

    function automatic void clear_track();
        clear_event();
        run_status = '0;
    endfunction

    // Variable-length quantity decoder; returns 1 on the final byte
    function automatic bit vlq_step(input logic [7:0] b, output logic [27:0] val);
        val = '0;
        if (vlq_cnt >= VLQ_LIMIT || vlq_acc[27:21] != '0)
            vlq_ovf = 1'b1;
        else
            vlq_acc = {vlq_acc[20:0], b[6:0]};
        if (vlq_cnt < 4'd15)
            vlq_cnt = vlq_cnt + 4'd1;
        if (b[7])
            return 1'b0;
        val = vlq_ovf ? VLQ_MAX : vlq_acc;
        if (vlq_ovf)
            evt_ovf = 1'b1;
        vlq_acc = '0;
        vlq_cnt = '0;
        vlq_ovf = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [3:0] kind_of(input logic [7:0] s, input logic [7:0] mt);
        if (s == ST_META) begin
            if (mt == MT_TEMPO)
                return CLS_TEMPO;
            if (mt == MT_TIME_SIG)
                return CLS_TIME_SIG;
            if (mt >= 8'h01 && mt <= 8'h0F)
                return CLS_META_TEXT;
            return CLS_META_OTHER;
        end
        if (s == ST_SYSEX || s == ST_SYSEX_ESC)
            return CLS_SYSEX;
        case (s[7:4])
            NIB_NOTE_OFF: return CLS_NOTE_OFF;
            NIB_NOTE_ON:  return CLS_NOTE_ON;
            NIB_CONTROL:  return CLS_CONTROL;
            NIB_PROGRAM:  return CLS_PROGRAM;
            default:      return CLS_OTHER;
        endcase
    endfunction

    function automatic bit valued_meta();
        return hold_mtype == MT_TEMPO || hold_mtype == MT_TIME_SIG;
    endfunction

    // Advance the model by one accepted byte, queue the event it yields
    function automatic void decode_byte(input logic [7:0] b, input logic ts, input logic lb);
        bit          emit;
        bit          done;
        bit          take_first;
        bit          voice;
        logic [1:0]  flt;
        logic [7:0]  second;
        logic [27:0] v;
        midi_event_t ev;
        emit       = 1'b0;
        done       = 1'b0;
        take_first = 1'b0;
        flt        = FLT_NONE;
        second     = '0;
        v          = '0;

        if (ts)
            clear_track();

        case (step_phase)
            PH_DELTA:
            begin
                if (vlq_step(b, v)) begin
                    hold_delta = v;
                    step_phase = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (b[7]) begin
                    reused     = 1'b0;
                    cur_status = b;
                    if (b == ST_META) begin
                        run_status = '0;
                        step_phase = PH_MTYPE;
                    end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                        run_status = '0;
                        step_phase = PH_SLEN;
                    end else if (b[7:4] == NIB_SYSTEM) begin
                        run_status = '0;
                        emit = 1'b1;
                        flt  = FLT_STATUS;
                        done = 1'b1;
                    end else begin
                        run_status = b;
                        step_phase = PH_DATA1;
                    end
                end else if (run_status == '0) begin
                    // data byte with no status to reuse
                    cur_status = '0;
                    hold_first = b;
                    emit = 1'b1;
                    flt  = FLT_STATUS;
                    done = 1'b1;
                end else begin
                    cur_status = run_status;
                    reused     = 1'b1;
                    take_first = 1'b1;
                end
            end
            PH_DATA1:
                take_first = 1'b1;
            PH_DATA2:
            begin
                second = b;
                emit   = 1'b1;
                done   = 1'b1;
            end
            PH_MTYPE:
            begin
                hold_mtype = b;
                step_phase = PH_MLEN;
            end
            PH_MLEN:
            begin
                if (vlq_step(b, v)) begin
                    remain    = v;
                    value_acc = valued_meta() ? 32'd0 : {4'h0, v};
                    if (!valued_meta() || v == '0)
                        emit = 1'b1;
                    if (v == '0)
                        done = 1'b1;
                    else
                        step_phase = PH_MPAY;
                end
            end
            PH_MPAY:
            begin
                if (valued_meta())
                    value_acc = {value_acc[23:0], b};
                remain = remain - 28'd1;
                if (remain == '0) begin
                    done = 1'b1;
                    if (valued_meta())
                        emit = 1'b1;
                end
            end
            PH_SLEN:
            begin
                if (vlq_step(b, v)) begin
                    remain    = v;
                    value_acc = {4'h0, v};
                    emit      = 1'b1;
                    if (v == '0)
                        done = 1'b1;
                    else
                        step_phase = PH_SPAY;
                end
            end
            PH_SPAY:
            begin
                remain = remain - 28'd1;
                if (remain == '0)
                    done = 1'b1;
            end
            default:
                done = 1'b1;
        endcase

        // first data byte of a voice event
        if (take_first) begin
            hold_first = b;
            if (cur_status[7:4] == NIB_PROGRAM || cur_status[7:4] == NIB_PRESSURE) begin
                emit = 1'b1;
                done = 1'b1;
            end else begin
                step_phase = PH_DATA2;
            end
        end

        // track ends inside an event
        if (lb && !done) begin
            if (!(step_phase == PH_DELTA && vlq_cnt == '0 && !vlq_ovf)) begin
                if (!emit) begin
                    emit   = 1'b1;
                    second = '0;
                end
                if (flt != FLT_STATUS)
                    flt = FLT_TRUNC;
            end
        end
        if (emit && flt == FLT_NONE && evt_ovf)
            flt = FLT_OVERFLOW;

        if (emit) begin
            voice     = cur_status[7] && cur_status[7:4] != NIB_SYSTEM;
            ev.kind   = kind_of(cur_status, hold_mtype);
            ev.chan   = voice ? cur_status[3:0] : 4'h0;
            ev.delta  = hold_delta;
            ev.status = cur_status;
            ev.first  = (voice || flt == FLT_STATUS) ? hold_first : 8'h00;
            ev.second = voice ? second : 8'h00;
            ev.value  = voice ? 32'd0 : value_acc;
            ev.mtype  = (cur_status == ST_META) ? hold_mtype : 8'h00;
            ev.reused = reused;
            ev.flt    = flt;
            events_due.push_back(ev);
        end

        if (lb)
            clear_track();
        else if (done)
            clear_event();
    endfunction

    // ------------------------------------------------------------------
    // Event checking
    // ------------------------------------------------------------------

    function automatic string show_event(input midi_event_t e);
        return $sformatf({"class=%0d ch=%0d delta=%h status=%h d1=%h d2=%h ",
                          "value=%h meta=%h run=%0b fault=%0d"},
                         e.kind, e.chan, e.delta, e.status, e.first, e.second,
                         e.value, e.mtype, e.reused, e.flt);
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endfunction

    always @(posedge clk) begin
        midi_event_t got;
        midi_event_t want;
        if (rst_n && event_valid && !event_stall) begin
            got = {event_class, channel, event_delta, status_byte, data_first,
                   data_second, payload_value, meta_type, running_used, fault};
            if (events_due.size() == 0) begin
                report_mismatch({"event with none due: ", show_event(got)});
            end else begin
                want = events_due.pop_front();
                if (got !== want)
                    report_mismatch({"expected ", show_event(want),
                                     " got ", show_event(got)});
            end
        end
    end

    // Receiver stall: runs of random length, mostly short
    always @(negedge clk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else if (!idle_on) begin
            event_stall <= 1'b0;
        end else begin
            event_stall <= ($urandom_range(0, 2) == 0);
            stall_run   <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                        : $urandom_range(0, 2);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Send one item; the model sees it on the edge that accepts it
    task automatic send_byte(input logic [7:0] b, input logic ts, input logic lb);
        int gap;
        int r;
        gap = 0;
        if (idle_on) begin
            r = $urandom_range(0, 99);
            if (r >= 92)
                gap = $urandom_range(10, 40);
            else if (r >= 55)
                gap = $urandom_range(1, 3);
        end
        @(negedge clk);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid  <= 1'b1;
        data_byte   <= b;
        track_start <= ts;
        last_byte   <= lb;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        decode_byte(b, ts, lb);
        bytes_sent++;
    endtask

    task automatic send_track(input bit with_ts, input bit with_lb);
        for (int i = 0; i < track_buf.size(); i++)
            send_byte(track_buf[i], with_ts && i == 0,
                      with_lb && i == track_buf.size() - 1);
    endtask

    function automatic void push_vlq(input logic [27:0] val, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            track_buf.push_back({i > 0, 7'((val >> (7 * i)) & 28'h7F)});
    endfunction

    function automatic logic [7:0] pick_data(input bit allow_hi);
        if (allow_hi && $urandom_range(0, 9) == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, 127));
    endfunction

    // Data bytes that a voice status calls for
    function automatic void push_voice_data(input logic [7:0] st, input bit allow_hi);
        track_buf.push_back(pick_data(allow_hi));
        if (st[7:4] != NIB_PROGRAM && st[7:4] != NIB_PRESSURE)
            track_buf.push_back(pick_data(1'b1));
    endfunction

    // Length prefix and payload for meta and sysex events
    function automatic void push_length(input int nominal);
        int len;
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            // overlong length: saturates, the rest of the track is payload
            push_vlq(28'($urandom), $urandom_range(5, 6));
            return;
        end
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : nominal;
        push_vlq(28'(len), (r < 12) ? 2 : 1);
        repeat (len)
            track_buf.push_back(8'($urandom));
    endfunction

    // One random track, mostly well-formed events with random content
    function automatic void build_track();
        logic [7:0] run_st;
        logic [7:0] st;
        logic [7:0] mt;
        int         n_events;
        int         r;
        int         keep;
        track_buf.delete();
        run_st   = 8'h00;
        n_events = $urandom_range(1, 6);
        for (int e = 0; e < n_events; e++) begin
            // delta time: mostly one byte, sometimes longer or overlong
            r = $urandom_range(0, 99);
            if (r < 70)
                push_vlq(28'($urandom_range(0, 127)), 1);
            else if (r < 88)
                push_vlq(28'($urandom), $urandom_range(2, 4));
            else if (r < 94)
                push_vlq(VLQ_MAX, 4);
            else
                push_vlq(28'($urandom), $urandom_range(5, 6));

            r = $urandom_range(0, 99);
            if (r < 40) begin
                st = 8'($urandom_range(8'h80, 8'hEF));
                track_buf.push_back(st);
                run_st = st;
                push_voice_data(st, 1'b1);
            end else if (r < 55) begin
                push_voice_data(run_st, 1'b0);
            end else if (r < 70) begin
                track_buf.push_back(ST_META);
                run_st = 8'h00;
                case ($urandom_range(0, 3))
                    0:       mt = MT_TEMPO;
                    1:       mt = MT_TIME_SIG;
                    2:       mt = 8'($urandom_range(1, 15));
                    default: mt = 8'($urandom);
                endcase
                track_buf.push_back(mt);
                push_length(mt == MT_TEMPO ? 3 : (mt == MT_TIME_SIG ? 4 : $urandom_range(0, 5)));
            end else if (r < 82) begin
                track_buf.push_back($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC);
                run_st = 8'h00;
                push_length($urandom_range(0, 5));
            end else if (r < 90) begin
                track_buf.push_back({NIB_SYSTEM, 4'($urandom_range(1, 14))});
                run_st = 8'h00;
            end else begin
                repeat ($urandom_range(1, 3))
                    track_buf.push_back(8'($urandom));
            end
        end

        // sometimes cut the track short
        if ($urandom_range(0, 9) == 0 && track_buf.size() > 1) begin
            keep = $urandom_range(1, track_buf.size() - 1);
            while (track_buf.size() > keep)
                void'(track_buf.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Note on, running status, longest delta time, program with high data bit
    task automatic test_voice_events();
        track_buf = '{8'h00, {NIB_NOTE_ON, 4'h0}, 8'h3C, 8'h40,
                      8'h00, 8'h3C, 8'h00,
                      8'hFF, 8'hFF, 8'hFF, 8'h7F, {NIB_PROGRAM, 4'hF}, 8'hFF};
        send_track(1'b1, 1'b0);
    endtask

    // Tempo meta event, value packed from its three payload bytes
    task automatic test_tempo_meta();
        track_buf = '{8'h00, ST_META, MT_TEMPO, 8'h03, 8'h07, 8'hA1, 8'h20};
        send_track(1'b0, 1'b0);
    endtask

    // Invalid status, then a data byte with no running status; track ends
    task automatic test_bad_status();
        track_buf = '{8'h00, {NIB_SYSTEM, 4'h4}, 8'h00, 8'h45};
        send_track(1'b0, 1'b1);
    endtask

    task automatic test_random_tracks(input int n_bytes, input bit with_idle);
        int stop_at;
        idle_on = with_idle;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            build_track();
            send_track(1'b1, $urandom_range(0, 9) != 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        data_byte   = 8'h00;
        track_start = 1'b0;
        last_byte   = 1'b0;
        clear_track();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_voice_events();
        test_tempo_meta();
        test_bad_status();
        test_random_tracks(100, 1'b0);
        test_random_tracks(310, 1'b1);

        @(negedge clk);
        item_valid <= 1'b0;
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
